[sv/dprc_pkg.sv]
// Package: shared types and constants for the determinant pair contribution block.
package dprc_pkg;

   localparam int ORB_W = 4;
   localparam int AMP_W = 32;
   localparam int PROD_W = 64;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_PLAN = 5'b00100,
      ST_SIGN = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      KIND_QUAD = 2'd0,
      KIND_SINGLE = 2'd1,
      KIND_DIAG = 2'd2
   } kind_type;

endpackage

[sv/dprc_sign.sv]
// Sign unit: one orbital flip and parity update per cycle over a quadruple.
module dprc_sign #(
   parameter int ORBITALS = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [dprc_pkg::ORB_W-1:0]  q0,
   input  logic [dprc_pkg::ORB_W-1:0]  q1,
   input  logic [dprc_pkg::ORB_W-1:0]  q2,
   input  logic [dprc_pkg::ORB_W-1:0]  q3,
   input  logic                        load_occ,
   input  logic [ORBITALS-1:0]         load_value,
   output logic                        done,
   output logic                        odd
);

   logic [ORBITALS-1:0]        occ_ff, occ_in;
   logic [dprc_pkg::ORB_W-1:0] s_ff [4];
   logic [dprc_pkg::ORB_W-1:0] s_in [4];
   logic [2:0]                 step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       odd_ff, odd_in;
   logic                       done_ff, done_in;
   logic [ORBITALS-1:0]        flipped, above;
   logic [dprc_pkg::ORB_W-1:0] cur;
   logic                       swap_a, swap_b;

   always_comb begin
      swap_a = !occ_ff[q2];
      swap_b = swap_a ? !occ_ff[q1] : !occ_ff[q3];
      cur = s_ff[step_ff[1:0]];
      flipped = occ_ff ^ (ORBITALS'(1) << cur);
      above = flipped >> cur;
      above = above >> 1;
      occ_in = occ_ff;
      s_in = s_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      odd_in = odd_ff;
      done_in = 1'b0;
      if (load_occ) begin
         occ_in = load_value;
      end else if (start) begin
         if (swap_a ^ swap_b) begin
            s_in[0] = q2; s_in[1] = q3; s_in[2] = q0; s_in[3] = q1;
         end else begin
            s_in[0] = q0; s_in[1] = q1; s_in[2] = q2; s_in[3] = q3;
         end
         step_in = 3'd3;
         busy_in = 1'b1;
         odd_in = 1'b0;
      end else if (busy_ff) begin
         occ_in = flipped;
         odd_in = odd_ff ^ (^above);
         if (step_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         step_in = step_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         occ_ff <= occ_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      s_ff <= s_in;
      odd_ff <= odd_in;
   end

   assign done = done_ff;
   assign odd = odd_ff;

endmodule

[sv/determinant_pair_rdm_contributions.sv]
// Top level: determinant pair two-particle density matrix contribution generator.
//  channel | ports                                               | direction
//  req     | req_valid req_ready, bra/ket mask, bra/ket amplitude | in
//  rsp     | rsp_valid rsp_ready, orb_i..l, contribution, flags   | out
// A pair is accepted in IDLE and classified and multiplied in MUL; an
// invalid pair presents its word straight from MUL, flagged last.
// Each quadruple passes through plan, the shared sign unit (start, four
// single-orbital flips, done), and the load of the output register.
// A degree-0 pair spends an extra plan step each time the first orbital
// moves, so 11 particles give 55 quadruples.
// Reset is synchronous and clears control state; a word waiting on rsp_ready
// stalls the sequencer, and req_ready is high only when idle with no word held.
module determinant_pair_rdm_contributions #(
   parameter int ORBITALS = 12,
   parameter int MAX_PARTICLES = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_bra_mask,
   input  logic [11:0] req_ket_mask,
   input  logic signed [31:0] req_bra_amplitude,
   input  logic signed [31:0] req_ket_amplitude,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_orb_i,
   output logic [3:0]  rsp_orb_j,
   output logic [3:0]  rsp_orb_k,
   output logic [3:0]  rsp_orb_l,
   output logic signed [63:0] rsp_contribution,
   output logic        rsp_valid_res,
   output logic        rsp_last
);

   localparam int OW = dprc_pkg::ORB_W;
   localparam int CW = $clog2(ORBITALS + 1);

   function automatic logic [OW:0] next_set(input logic [ORBITALS-1:0] v,
                                            input logic [OW-1:0] z, input logic incl);
      logic [OW:0] res;
      res = '0;
      for (int n = ORBITALS - 1; n >= 0; n--) begin
         if (v[n] && (OW'(n) > z || (incl && OW'(n) == z))) res = {1'b1, OW'(n)};
      end
      return res;
   endfunction

   dprc_pkg::state_type state_ff, state_in;
   dprc_pkg::kind_type  kind_ff, kind_in;
   logic [ORBITALS-1:0] bra_ff, ket_ff, bra_in, ket_in;
   logic signed [31:0]  a_ff, b_ff, a_in, b_in;
   logic signed [63:0]  prod_ff, prod_in;
   logic [OW-1:0]       x_ff, y_ff, x_in, y_in;
   logic [OW-1:0]       p_ff, r_ff, p_in, r_in;
   logic                adv_ff, adv_in;
   logic                rv_ff, rv_in;
   logic [OW-1:0]       oi_ff, oj_ff, ok_ff, ol_ff, oi_in, oj_in, ok_in, ol_in;
   logic signed [63:0]  oc_ff, oc_in;
   logic                ovr_ff, ovr_in, olast_ff, olast_in;
   logic                final_ff, final_in;

   logic [ORBITALS-1:0] diff, common, bm, km;
   logic [CW-1:0]       nb, nk, nd;
   logic                sign_start, sign_load, sign_done, sign_odd;
   logic [OW-1:0]       r0, r1, r2, r3;
   logic [OW-1:0]       c0, c1, c2, c3, t;
   logic [OW-1:0]       nc, nx, ny, n0c, n0k;
   logic                hc, hx, hy, h0c, h0k;
   logic [OW-1:0]       f1, f2, g1, g2;
   logic [1:0]          fc, gc;
   logic                bad;

   dprc_sign #(.ORBITALS(ORBITALS)) u_sign (
      .clock(clock), .reset(reset), .start(sign_start),
      .q0(c0), .q1(c1), .q2(c2), .q3(c3),
      .load_occ(sign_load), .load_value(ket_ff),
      .done(sign_done), .odd(sign_odd)
   );

   always_comb begin
      bm = ORBITALS'(req_bra_mask);
      km = ORBITALS'(req_ket_mask);
      diff = bra_ff ^ ket_ff;
      common = bra_ff & ket_ff;
      nb = '0; nk = '0; nd = '0;
      f1 = '0; f2 = '0; g1 = '0; g2 = '0; fc = '0; gc = '0;
      for (int n = 0; n < ORBITALS; n++) begin
         nb = nb + CW'(bra_ff[n]);
         nk = nk + CW'(ket_ff[n]);
         nd = nd + CW'(diff[n]);
         if (diff[n] & bra_ff[n]) begin
            if (fc == 2'd0) f1 = OW'(n); else f2 = OW'(n);
            fc = fc + 2'd1;
         end
         if (diff[n] & ket_ff[n]) begin
            if (gc == 2'd0) g1 = OW'(n); else g2 = OW'(n);
            gc = gc + 2'd1;
         end
      end
      {hc, nc} = next_set(common, x_ff, 1'b0);
      {hx, nx} = next_set(ket_ff, x_ff, 1'b0);
      {hy, ny} = next_set(ket_ff, y_ff, 1'b0);
      {h0c, n0c} = next_set(common, '0, 1'b1);
      {h0k, n0k} = next_set(ket_ff, '0, 1'b1);
      unique case (kind_ff)
         dprc_pkg::KIND_QUAD: begin
            r0 = p_ff; r1 = x_ff; r2 = r_ff; r3 = y_ff;
         end
         dprc_pkg::KIND_SINGLE: begin
            r0 = p_ff; r1 = x_ff; r2 = x_ff; r3 = r_ff;
         end
         default: begin
            r0 = x_ff; r1 = y_ff; r2 = x_ff; r3 = y_ff;
         end
      endcase
      c0 = r0; c1 = r1; c2 = r2; c3 = r3;
      if (c0 > c1) begin t = c0; c0 = c1; c1 = t; end
      if (c2 > c3) begin t = c2; c2 = c3; c3 = t; end
      if (c0 > c2 || (c0 == c2 && c1 > c3)) begin
         t = c0; c0 = c2; c2 = t;
         t = c1; c1 = c3; c3 = t;
      end
      bad = a_ff == '0 || b_ff == '0 || nb != nk || nk > CW'(MAX_PARTICLES)
            || nd > CW'(4) || (nd == CW'(2) && !h0c) || (nd == CW'(0) && nk < CW'(2))
            || (nd == CW'(0) && !h0k);
   end

   always_comb begin
      state_in = state_ff; kind_in = kind_ff;
      bra_in = bra_ff; ket_in = ket_ff; a_in = a_ff; b_in = b_ff; prod_in = prod_ff;
      x_in = x_ff; y_in = y_ff; p_in = p_ff; r_in = r_ff; adv_in = adv_ff;
      rv_in = rv_ff && !rsp_ready;
      oi_in = oi_ff; oj_in = oj_ff; ok_in = ok_ff; ol_in = ol_ff;
      oc_in = oc_ff; ovr_in = ovr_ff; olast_in = olast_ff;
      final_in = final_ff;
      sign_start = 1'b0; sign_load = 1'b0;
      req_ready = (state_ff == dprc_pkg::ST_IDLE) && !rv_ff;
      unique case (state_ff)
         dprc_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               bra_in = bm; ket_in = km;
               a_in = req_bra_amplitude; b_in = req_ket_amplitude;
               state_in = dprc_pkg::ST_MUL;
            end
         end
         dprc_pkg::ST_MUL: begin
            prod_in = a_ff * b_ff;
            sign_load = 1'b1;
            if (bad) begin
               state_in = dprc_pkg::ST_IDLE;
               oi_in = '0; oj_in = '0; ok_in = '0; ol_in = '0;
               oc_in = '0; ovr_in = 1'b0; olast_in = 1'b1;
               rv_in = 1'b1;
            end else begin
               state_in = dprc_pkg::ST_PLAN;
               adv_in = 1'b0;
               if (nd == CW'(4)) begin
                  kind_in = dprc_pkg::KIND_QUAD;
                  p_in = f1; x_in = f2; r_in = g1; y_in = g2;
               end else if (nd == CW'(2)) begin
                  kind_in = dprc_pkg::KIND_SINGLE;
                  p_in = f1; r_in = g1; x_in = n0c;
               end else begin
                  kind_in = dprc_pkg::KIND_DIAG;
                  x_in = n0k; y_in = n0k; adv_in = 1'b1;
               end
            end
         end
         dprc_pkg::ST_PLAN: begin
            if (adv_ff) begin
               y_in = ny;
               adv_in = 1'b0;
            end else begin
               sign_start = 1'b1;
               state_in = dprc_pkg::ST_SIGN;
               priority if (kind_ff == dprc_pkg::KIND_SINGLE) final_in = !hc;
               else if (kind_ff == dprc_pkg::KIND_DIAG) final_in = !hy && (nx == y_ff);
               else final_in = 1'b1;
            end
         end
         dprc_pkg::ST_SIGN: begin
            if (sign_done) state_in = dprc_pkg::ST_OUT;
         end
         dprc_pkg::ST_OUT: begin
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               oi_in = c0; oj_in = c1; ok_in = c2; ol_in = c3;
               oc_in = sign_odd ? prod_ff : -prod_ff;
               ovr_in = 1'b1; olast_in = final_ff;
               if (final_ff) begin
                  state_in = dprc_pkg::ST_IDLE;
               end else begin
                  state_in = dprc_pkg::ST_PLAN;
                  if (kind_ff == dprc_pkg::KIND_SINGLE) begin
                     x_in = nc;
                  end else if (kind_ff == dprc_pkg::KIND_DIAG) begin
                     if (hy) begin
                        y_in = ny;
                     end else begin
                        x_in = nx; y_in = nx; adv_in = 1'b1;
                     end
                  end
               end
            end
         end
         default: state_in = dprc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dprc_pkg::ST_IDLE;
         rv_ff <= 1'b0;
         final_ff <= 1'b0;
         adv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         final_ff <= final_in;
         adv_ff <= adv_in;
      end
      kind_ff <= kind_in;
      bra_ff <= bra_in; ket_ff <= ket_in; prod_ff <= prod_in;
      a_ff <= a_in; b_ff <= b_in;
      x_ff <= x_in; y_ff <= y_in; p_ff <= p_in; r_ff <= r_in;
      oi_ff <= oi_in; oj_ff <= oj_in; ok_ff <= ok_in; ol_ff <= ol_in;
      oc_ff <= oc_in; ovr_ff <= ovr_in; olast_ff <= olast_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_orb_i = oi_ff;
   assign rsp_orb_j = oj_ff;
   assign rsp_orb_k = ok_ff;
   assign rsp_orb_l = ol_ff;
   assign rsp_contribution = oc_ff;
   assign rsp_valid_res = ovr_ff;
   assign rsp_last = olast_ff;

endmodule
